[rtl/elfr_pkg.sv]
// Shared constants, codes and types for the escaped LED frame receiver.
package elfr_pkg;

  localparam int LedCount = 61;
  localparam int BankSize = LedCount * 3;
  localparam int LedW = $clog2(LedCount + 1);
  localparam int AddrW = $clog2(2 * LedCount);
  localparam int LaneCount = 3;

  localparam logic [7:0] SyncByte = 8'hE0;
  localparam logic [7:0] EscByte = 8'hD0;
  localparam logic [23:0] TimeoutReset = 24'd2000000;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_BOARD_ID = 1'b0,
    REG_TIMEOUT  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    LANE_RED   = 2'd0,
    LANE_GREEN = 2'd1,
    LANE_BLUE  = 2'd2
  } lane_t;

  typedef struct packed {
    logic [LaneCount-1:0] we;
    logic [AddrW-1:0]     addr;
    logic [7:0]           data;
  } mem_wr_t;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic color_ok;
    logic active;
    logic accepted;
    logic rejected;
  } step_res_t;

endpackage

[rtl/elfr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module elfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/elfr_ctrl.sv]
// Frame parser, bank control and timeout counter; drives the colour RAM ports.
module elfr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  elfr_pkg::op_t          op,
  input  logic [7:0]             data_byte,
  input  logic [7:0]             led_index,
  input  logic [7:0]             board_id,
  input  logic [23:0]            timeout_ticks,
  output elfr_pkg::mem_wr_t      wr,
  output elfr_pkg::mem_rd_t      rd,
  output elfr_pkg::step_res_t    res
);

  logic                       in_frame_r, in_frame_nxt;
  logic                       esc_r, esc_nxt;
  logic [7:0]                 pos_r, pos_nxt;
  logic [7:0]                 rid_r, rid_nxt;
  elfr_pkg::lane_t            lane_r, lane_nxt;
  logic [elfr_pkg::LedW-1:0]  led_r, led_nxt;
  logic                       shown_r, shown_nxt;
  logic                       present_r, present_nxt;
  logic [23:0]                ticks_r, ticks_nxt;
  logic [7:0]                 bval;
  logic [elfr_pkg::AddrW-1:0] wr_base;
  logic [elfr_pkg::AddrW-1:0] rd_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      pos_r      <= '0;
      rid_r      <= '0;
      lane_r     <= elfr_pkg::LANE_RED;
      led_r      <= '0;
      shown_r    <= 1'b0;
      present_r  <= 1'b0;
      ticks_r    <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      pos_r      <= pos_nxt;
      rid_r      <= rid_nxt;
      lane_r     <= lane_nxt;
      led_r      <= led_nxt;
      shown_r    <= shown_nxt;
      present_r  <= present_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

  // Frames are assembled in the bank that is not shown.
  assign wr_base = shown_r ? '0 : elfr_pkg::AddrW'(elfr_pkg::LedCount);
  assign rd_base = shown_r ? elfr_pkg::AddrW'(elfr_pkg::LedCount) : '0;
  assign bval = esc_r ? data_byte + 8'd1 : data_byte;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    pos_nxt      = pos_r;
    rid_nxt      = rid_r;
    lane_nxt     = lane_r;
    led_nxt      = led_r;
    shown_nxt    = shown_r;
    present_nxt  = present_r;
    ticks_nxt    = ticks_r;
    wr.we        = '0;
    wr.addr      = wr_base + elfr_pkg::AddrW'(led_r);
    wr.data      = bval;
    rd.re        = 1'b0;
    rd.addr      = rd_base + elfr_pkg::AddrW'(led_index);
    res.color_ok = 1'b0;
    res.accepted = 1'b0;
    res.rejected = 1'b0;
    if (accept) begin
      case (op)
        elfr_pkg::OP_BYTE: begin
          if (!in_frame_r) begin
            if (data_byte == elfr_pkg::SyncByte) begin
              in_frame_nxt = 1'b1;
              esc_nxt      = 1'b0;
              pos_nxt      = '0;
              lane_nxt     = elfr_pkg::LANE_RED;
              led_nxt      = '0;
            end
          end else if (data_byte == elfr_pkg::EscByte && !esc_r) begin
            esc_nxt = 1'b1;
          end else begin
            esc_nxt = 1'b0;
            if (pos_r == 8'd0) begin
              rid_nxt = bval;
            end else begin
              wr.we[lane_r] = 1'b1;
              if (lane_r == elfr_pkg::LANE_BLUE) begin
                lane_nxt = elfr_pkg::LANE_RED;
                led_nxt  = led_r + 1'b1;
              end else begin
                lane_nxt = elfr_pkg::lane_t'(lane_r + 2'd1);
              end
            end
            if (pos_r == 8'(elfr_pkg::BankSize)) begin
              in_frame_nxt = 1'b0;
              pos_nxt      = '0;
              if (rid_r == board_id) begin
                shown_nxt    = ~shown_r;
                present_nxt  = 1'b1;
                ticks_nxt    = timeout_ticks;
                res.accepted = 1'b1;
              end else begin
                res.rejected = 1'b1;
              end
            end else begin
              pos_nxt = pos_r + 8'd1;
            end
          end
        end
        elfr_pkg::OP_TICK: begin
          if (ticks_r != '0) begin
            ticks_nxt = ticks_r - 24'd1;
          end
        end
        elfr_pkg::OP_READ: begin
          rd.re        = 1'b1;
          res.color_ok = present_r && (led_index < 8'(elfr_pkg::LedCount));
        end
        default: begin
        end
      endcase
    end
    res.active = (ticks_nxt != '0);
  end

endmodule

[rtl/escaped_led_frame_receiver_unit.sv]
// Top level of the escaped LED frame receiver: config, colour RAMs, result stage.
//
//   channel  ports                                         direction
//   input    in_valid/in_ready, operation, byte, index     in
//   result   out_valid/out_ready, color, flags             out
//   config   cfg_we, cfg_index, cfg_wdata                  in
//
// One transaction per cycle unless stalled; its result appears in the next cycle.
// Colour reads go through the registered read port of the RAMs.
// A stalled result holds in the result stage and blocks new input until taken.
// Reset clears the parser, bank select and timeout; RAM contents are not cleared.
module escaped_led_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_led_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_color,
  output logic        out_active,
  output logic        out_frame_accepted,
  output logic        out_frame_rejected,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  logic [7:0]            board_id_r;
  logic [23:0]           timeout_r;
  logic                  accept;
  logic                  out_valid_r;
  elfr_pkg::step_res_t   res;
  elfr_pkg::step_res_t   res_r;
  elfr_pkg::mem_wr_t     wr;
  elfr_pkg::mem_rd_t     rd;
  logic [7:0]            lane_rdata [elfr_pkg::LaneCount];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_id_r <= '0;
      timeout_r  <= elfr_pkg::TimeoutReset;
    end else if (cfg_we) begin
      case (elfr_pkg::reg_idx_t'(cfg_index))
        elfr_pkg::REG_BOARD_ID: board_id_r <= cfg_wdata[7:0];
        elfr_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  elfr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .op            (elfr_pkg::op_t'(in_operation)),
    .data_byte     (in_data_byte),
    .led_index     (in_led_index),
    .board_id      (board_id_r),
    .timeout_ticks (timeout_r),
    .wr            (wr),
    .rd            (rd),
    .res           (res)
  );

  // One byte lane per colour, so a read returns a whole LED at once.
  for (genvar g = 0; g < elfr_pkg::LaneCount; g++) begin : g_lane
    elfr_ram #(
      .Width (8),
      .Depth (2 * elfr_pkg::LedCount)
    ) u_ram (
      .clk   (clk),
      .we    (wr.we[g]),
      .waddr (wr.addr),
      .wdata (wr.data),
      .re    (rd.re),
      .raddr (rd.addr),
      .rdata (lane_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
      if (in_valid) begin
        res_r <= res;
      end
    end
  end

  // RAM read data only changes on an accepted read, so it holds during a stall.
  assign out_valid          = out_valid_r;
  assign out_color          = res_r.color_ok ?
                              {lane_rdata[0], lane_rdata[1], lane_rdata[2]} : 24'd0;
  assign out_active         = res_r.active;
  assign out_frame_accepted = res_r.accepted;
  assign out_frame_rejected = res_r.rejected;

endmodule
